/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)

`endif

`endif

/* sv/fasc_pkg.sv */
// ----------------------------------------------------------------------------
// fasc_pkg
// constants shared by the fire alarm state controller
// ----------------------------------------------------------------------------
package fasc_pkg;

	localparam int MAX_DIGITS_DEF = 8;

	localparam int TEMP_W  = 10;
	localparam int SMOKE_W = 7;
	localparam int KEY_W   = 8;
	localparam int PW_W    = 32;
	localparam int LEN_W   = 4;
	localparam int NIB_W   = 4;
	localparam int PW_NIBBLES = 8;
	localparam int EV_W    = 3;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 16;

	localparam logic [KEY_W-1:0] KEY_ONE  = 8'h31;
	localparam logic [KEY_W-1:0] KEY_EQ   = 8'h3D;
	localparam logic [KEY_W-1:0] KEY_ZERO = 8'h30;
	localparam logic [KEY_W-1:0] KEY_NINE = 8'h39;

	localparam logic [EV_W-1:0] EV_NONE  = 3'd0;
	localparam logic [EV_W-1:0] EV_MODE  = 3'd1;
	localparam logic [EV_W-1:0] EV_DIGIT = 3'd2;
	localparam logic [EV_W-1:0] EV_OK    = 3'd3;
	localparam logic [EV_W-1:0] EV_BAD   = 3'd4;

	localparam logic [2:0] REG_HEAT_ENTER  = 3'd0;
	localparam logic [2:0] REG_FINE_RETURN = 3'd1;
	localparam logic [2:0] REG_SMOKE_FIRE  = 3'd2;
	localparam logic [2:0] REG_PW_DIGITS   = 3'd3;
	localparam logic [2:0] REG_PW_LENGTH   = 3'd4;

	localparam logic [TEMP_W-1:0]  HEAT_ENTER_RST  = 10'd50;
	localparam logic [TEMP_W-1:0]  FINE_RETURN_RST = 10'd45;
	localparam logic [SMOKE_W-1:0] SMOKE_FIRE_RST  = 7'd50;
	localparam logic [PW_W-1:0]    PW_DIGITS_RST   = 32'd0;
	localparam logic [LEN_W-1:0]   PW_LENGTH_RST   = 4'd4;
	localparam logic [LEN_W-1:0]   PW_LEN_MAX      = 4'd8;

endpackage

/* sv/fire_alarm_state_controller.sv */
// ----------------------------------------------------------------------------
// fire_alarm_state_controller
// fine / heat / fire / password mode controller with keypad password entry
// ----------------------------------------------------------------------------
// an accepted input is held in the input register, then moves to the result register once the output is free
// throughput: one item per cycle while m_tready is high, set by the single-pass mode update logic
// reset: mode to fine, digit count to zero, registers to their defaults
// the entered password digits are not cleared by reset
`include "assert_macros.svh"

module fire_alarm_state_controller #(
	parameter int MAX_DIGITS = fasc_pkg::MAX_DIGITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// temperature[9:0], smoke_percent[16:10], key_code[24:17]
	input  logic [fasc_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// mode[1:0], led_fine[2], led_heat[3], led_fire[4], digits_entered[8:5],
	// event_res[11:9]
	output logic [fasc_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [fasc_pkg::ADDR_W-1:0]      paddr,
	input  logic [fasc_pkg::DATA_W-1:0]      pwdata,
	output logic [fasc_pkg::DATA_W-1:0]      prdata,
	output logic                             pready
);

	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int CMPW = (CW > fasc_pkg::LEN_W) ? CW : fasc_pkg::LEN_W;

	typedef enum logic [1:0] {
		MODE_FINE,
		MODE_HEAT,
		MODE_FIRE,
		MODE_PASS
	} mode_t;

	// configuration registers
	logic [fasc_pkg::TEMP_W-1:0]  heat_enter_q;
	logic [fasc_pkg::TEMP_W-1:0]  fine_return_q;
	logic [fasc_pkg::SMOKE_W-1:0] smoke_fire_q;
	logic [fasc_pkg::PW_W-1:0]    pw_digits_q;
	logic [fasc_pkg::LEN_W-1:0]   pw_length_q;

	logic cfg_wr;
	logic [2:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heat_enter_q  <= fasc_pkg::HEAT_ENTER_RST;
			fine_return_q <= fasc_pkg::FINE_RETURN_RST;
			smoke_fire_q  <= fasc_pkg::SMOKE_FIRE_RST;
			pw_digits_q   <= fasc_pkg::PW_DIGITS_RST;
			pw_length_q   <= fasc_pkg::PW_LENGTH_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				fasc_pkg::REG_HEAT_ENTER:  heat_enter_q  <= pwdata[fasc_pkg::TEMP_W-1:0];
				fasc_pkg::REG_FINE_RETURN: fine_return_q <= pwdata[fasc_pkg::TEMP_W-1:0];
				fasc_pkg::REG_SMOKE_FIRE:  smoke_fire_q  <= pwdata[fasc_pkg::SMOKE_W-1:0];
				fasc_pkg::REG_PW_DIGITS:   pw_digits_q   <= pwdata[fasc_pkg::PW_W-1:0];
				fasc_pkg::REG_PW_LENGTH:   pw_length_q   <= pwdata[fasc_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			fasc_pkg::REG_HEAT_ENTER:  prdata = fasc_pkg::DATA_W'(heat_enter_q);
			fasc_pkg::REG_FINE_RETURN: prdata = fasc_pkg::DATA_W'(fine_return_q);
			fasc_pkg::REG_SMOKE_FIRE:  prdata = fasc_pkg::DATA_W'(smoke_fire_q);
			fasc_pkg::REG_PW_DIGITS:   prdata = fasc_pkg::DATA_W'(pw_digits_q);
			fasc_pkg::REG_PW_LENGTH:   prdata = fasc_pkg::DATA_W'(pw_length_q);
			default:                   prdata = '0;
		endcase
	end

	// input register
	logic                         valid_s1;
	logic [fasc_pkg::TEMP_W-1:0]  temp_s1;
	logic [fasc_pkg::SMOKE_W-1:0] smoke_s1;
	logic [fasc_pkg::KEY_W-1:0]   key_s1;
	logic                         advance;
	logic                         out_valid_q;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			temp_s1  <= s_tdata[9:0];
			smoke_s1 <= s_tdata[16:10];
			key_s1   <= s_tdata[24:17];
		end
	end

	// state
	mode_t                      mode_q;
	logic [CW-1:0]              count_q;
	logic [fasc_pkg::NIB_W-1:0] digits_q [MAX_DIGITS];

	// password compare, one lane per nibble
	logic [fasc_pkg::PW_NIBBLES-1:0] lane_ok;

	for (genvar i = 0; i < fasc_pkg::PW_NIBBLES; i++) begin : g_lane
		if (i < MAX_DIGITS) begin : g_used
			assign lane_ok[i] = (fasc_pkg::LEN_W'(i) >= pw_length_q) ||
				(digits_q[i] == pw_digits_q[4*i +: 4]);
		end else begin : g_none
			assign lane_ok[i] = 1'b1;
		end
	end

	logic                         pw_match;
	logic                         is_digit;
	logic [fasc_pkg::KEY_W-1:0]   key_off;
	logic [fasc_pkg::NIB_W-1:0]   digit_val;
	logic                         room;
	mode_t                        mode_d;
	logic [CW-1:0]                count_d;
	logic [fasc_pkg::EV_W-1:0]    ev_d;
	logic                         dig_we;
	logic [CW+3:0]                count_ext;

	assign pw_match  = (pw_length_q <= fasc_pkg::PW_LEN_MAX) &&
		(CMPW'(count_q) == CMPW'(pw_length_q)) && (&lane_ok);
	assign is_digit  = (key_s1 >= fasc_pkg::KEY_ZERO) && (key_s1 <= fasc_pkg::KEY_NINE);
	assign key_off   = key_s1 - fasc_pkg::KEY_ZERO;
	assign digit_val = key_off[fasc_pkg::NIB_W-1:0];
	assign room      = count_q < CW'(MAX_DIGITS);

	always_comb begin
		mode_d  = mode_q;
		count_d = count_q;
		ev_d    = fasc_pkg::EV_NONE;
		dig_we  = 1'b0;
		unique case (mode_q)
			MODE_FINE: begin
				if (temp_s1 > heat_enter_q) begin
					mode_d = MODE_HEAT;
					ev_d   = fasc_pkg::EV_MODE;
				end
			end
			MODE_HEAT: begin
				priority if (smoke_s1 > smoke_fire_q) begin
					mode_d = MODE_FIRE;
					ev_d   = fasc_pkg::EV_MODE;
				end else if (smoke_s1 < smoke_fire_q && temp_s1 < fine_return_q) begin
					mode_d = MODE_FINE;
					ev_d   = fasc_pkg::EV_MODE;
				end else begin
				end
			end
			MODE_FIRE: begin
				if (key_s1 == fasc_pkg::KEY_ONE) begin
					mode_d = MODE_PASS;
					ev_d   = fasc_pkg::EV_MODE;
				end
			end
			MODE_PASS: begin
				priority if (is_digit) begin
					if (room) begin
						dig_we  = 1'b1;
						count_d = count_q + CW'(1);
						ev_d    = fasc_pkg::EV_DIGIT;
					end
				end else if (key_s1 == fasc_pkg::KEY_EQ) begin
					count_d = '0;
					if (pw_match) begin
						mode_d = MODE_FINE;
						ev_d   = fasc_pkg::EV_OK;
					end else begin
						ev_d   = fasc_pkg::EV_BAD;
					end
				end else begin
				end
			end
			default: ;
		endcase
	end

	assign count_ext = {4'b0, count_d};

	// result register
	mode_t                      out_mode_q;
	logic [3:0]                 out_count_q;
	logic [fasc_pkg::EV_W-1:0]  out_ev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_FINE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			out_mode_q  <= MODE_FINE;
			out_count_q <= '0;
			out_ev_q    <= fasc_pkg::EV_NONE;
		end else begin
			if (advance) begin
				mode_q      <= mode_d;
				count_q     <= count_d;
				out_mode_q  <= mode_d;
				out_count_q <= count_ext[3:0];
				out_ev_q    <= ev_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && dig_we) begin
			digits_q[count_q[IW-1:0]] <= digit_val;
		end
	end

	logic led_fine;
	logic led_heat;
	logic led_fire;

	assign led_fine = (out_mode_q == MODE_FINE);
	assign led_heat = (out_mode_q == MODE_HEAT);
	assign led_fire = (out_mode_q == MODE_FIRE) || (out_mode_q == MODE_PASS);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_ev_q, out_count_q, led_fire, led_heat, led_fine, out_mode_q};

	`ASSERT_ALWAYS(a_count_range, clk, arst_n, count_q <= CW'(MAX_DIGITS))
	`ASSERT_IMPL(a_mode_tracks_state, clk, arst_n, out_valid_q, out_mode_q == mode_q)
	`ASSERT_IMPL(a_ok_is_fine, clk, arst_n, out_valid_q && out_ev_q == fasc_pkg::EV_OK, out_mode_q == MODE_FINE)
	`ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !out_valid_q, s_tready)
	`ASSERT_ALWAYS(a_one_lamp, clk, arst_n, $onehot({led_fine, led_heat, led_fire}))

endmodule
